// ----- rtl/tccw_pkg.sv -----
package tccw_pkg;

   // Screen geometry
   localparam int SCREEN_COLUMNS = 80;
   localparam int SCREEN_ROWS    = 25;

   // Field widths
   localparam int CHAR_W   = 8;
   localparam int COLOR_W  = 8;
   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int ADDR_W   = 11;
   localparam int WORD_W   = CHAR_W + COLOR_W;
   localparam int RSP_W    = 32;
   // Wide enough for row * SCREEN_COLUMNS + column before truncation
   localparam int ADDR_FULL_W = ROW_W + COL_W + 1;

   // Character codes
   localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CODE_BLANK     = 8'd32;

   localparam logic [COLOR_W-1:0] COLOR_AT_RESET = 8'h07;

   // One cell write
   typedef struct packed {
      logic [WORD_W-1:0] cell_word;
      logic [ADDR_W-1:0] cell_address;
   } cell_type;

   // Result of one item, with its valid flag
   typedef struct packed {
      logic     valid;
      cell_type wr_cell;
   } result_type;

endpackage

// ----- rtl/tccw_cursor.sv -----
module tccw_cursor
   import tccw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [CHAR_W-1:0]  char_code,
   input  logic [COLOR_W-1:0] text_color,
   output result_type         result
);

   logic [COL_W-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [COL_W:0]         col_plus;
   logic [ROW_W:0]         row_plus;
   logic [ROW_W-1:0]       row_next;
   logic [COL_W-1:0]       write_col;
   logic [ADDR_FULL_W-1:0] addr_full;
   logic [CHAR_W-1:0]      write_char;
   logic                   write_en;

   // Next row with wrap to the top (no scrolling)
   assign row_plus = {1'b0, row_ff} + 1'b1;
   assign row_next = (row_plus >= (ROW_W+1)'(SCREEN_ROWS)) ? '0 : row_plus[ROW_W-1:0];
   assign col_plus = {1'b0, col_ff} + 1'b1;

   // Decode the character and work out the cursor move
   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      write_col  = col_ff;
      write_char = char_code;
      write_en   = 1'b0;
      unique case (char_code)
         CODE_NEWLINE: begin
            col_in = '0;
            row_in = row_next;
         end
         CODE_BACKSPACE: begin
            // Step back and blank, nothing at column zero
            if (col_ff != '0) begin
               col_in     = col_ff - 1'b1;
               write_col  = col_ff - 1'b1;
               write_char = CODE_BLANK;
               write_en   = 1'b1;
            end
         end
         default: begin
            write_en = 1'b1;
            if (col_plus >= (COL_W+1)'(SCREEN_COLUMNS)) begin
               col_in = '0;
               row_in = row_next;
            end else begin
               col_in = col_plus[COL_W-1:0];
            end
         end
      endcase
   end

   // Linear cell index, low bits kept
   assign addr_full = ADDR_FULL_W'(row_ff) * ADDR_FULL_W'(SCREEN_COLUMNS)
                    + ADDR_FULL_W'(write_col);

   assign result.valid                = accept & write_en;
   assign result.wr_cell.cell_address = addr_full[ADDR_W-1:0];
   assign result.wr_cell.cell_word    = {text_color, write_char};

   // Hold the cursor, advance on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   a_col_range : assert property (@(posedge clock) disable iff (reset)
      {1'b0, col_ff} < (COL_W+1)'(SCREEN_COLUMNS))
      else $error("cursor column beyond screen width");

   a_row_range : assert property (@(posedge clock) disable iff (reset)
      {1'b0, row_ff} < (ROW_W+1)'(SCREEN_ROWS))
      else $error("cursor row beyond screen height");

   a_newline_home : assert property (@(posedge clock) disable iff (reset)
      accept && char_code == CODE_NEWLINE |=> col_ff == '0)
      else $error("newline did not return cursor to column zero");

endmodule

// ----- rtl/tccw_out_stage.sv -----
module tccw_out_stage
   import tccw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  result_type result,
   output logic       space,
   output logic       out_valid,
   output cell_type   out_cell,
   input  logic       out_ready
);

   logic     out_valid_ff;
   logic     skid_valid_ff;
   cell_type out_cell_ff;
   cell_type skid_cell_ff;
   logic     out_take;

   assign out_take  = out_valid_ff & out_ready;
   assign space     = ~skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_cell  = out_cell_ff;

   // Output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            out_cell_ff   <= skid_cell_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (result.valid) begin
         if (out_valid_ff && !out_take) begin
            skid_cell_ff  <= result.wr_cell;
            skid_valid_ff <= 1'b1;
         end else begin
            out_cell_ff  <= result.wr_cell;
            out_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_no_drop : assert property (@(posedge clock) disable iff (reset)
      result.valid && out_valid_ff && !out_ready |=> skid_valid_ff)
      else $error("stalled item not parked in skid entry");

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !result.valid)
      else $error("item arrived while skid entry full");

endmodule

// ----- rtl/text_console_cell_writer_top.sv -----
// Channel   Direction  Item
// req_*     in         character byte
// rsp_*     out        cell write (address, word)
// csr_*     in         text color register write
//
// One character per cycle while req_tready is high; each item updates the
// cursor in the cycle it is accepted; its cell write is then registered.
// Reset (synchronous) homes the cursor to row 0, column 0 and sets color 7.
// A stalled result is parked in a one-entry skid register; req_tready drops
// only while that entry is full.
module text_console_cell_writer_top
   import tccw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // char_code [7:0]
   input  logic [CHAR_W-1:0]   req_tdata,
   input  logic                req_tvalid,
   output logic                req_tready,
   // cell_address [10:0], cell_word [26:11], zero [31:27]
   output logic [RSP_W-1:0]    rsp_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // text_color [7:0]
   input  logic [COLOR_W-1:0]  csr_data,
   input  logic                csr_valid,
   output logic                csr_ready
);

   logic [COLOR_W-1:0] color_ff;
   logic               req_accept;
   logic               space;
   result_type         result;
   cell_type           out_cell;

   assign csr_ready  = 1'b1;
   assign req_tready = space;
   assign req_accept = req_tvalid & space;

   // Hold the color register
   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= COLOR_AT_RESET;
      end else if (csr_valid) begin
         color_ff <= csr_data;
      end
   end

   tccw_cursor u_cursor (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .char_code  (req_tdata),
      .text_color (color_ff),
      .result     (result)
   );

   tccw_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_cell  (out_cell),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {(RSP_W-ADDR_W-WORD_W)'(0), out_cell.cell_word, out_cell.cell_address};

endmodule

// ----- verif/tccw_checker.sv -----
module tccw_checker
   import tccw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [CHAR_W-1:0]  req_tdata,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [RSP_W-1:0]   rsp_tdata,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [COLOR_W-1:0] csr_data,
   input  logic               csr_valid,
   input  logic               csr_ready,
   output int                 pending,
   output int                 errors
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow of the cursor and the color register
   logic [COL_W-1:0]   cur_col;
   logic [ROW_W-1:0]   cur_row;
   logic [COLOR_W-1:0] cur_color;

   // Cell writes still owed by the block, oldest first
   cell_type owed_cells[$];

   // Apply one character to the shadow cursor; return 1 when it writes a cell
   function automatic logic advance_cursor(input logic [CHAR_W-1:0] ch,
                                           output cell_type wr_cell);
      int col;
      int row;
      logic writes;
      col     = cur_col;
      row     = cur_row;
      writes  = 1'b0;
      wr_cell = '0;
      if (ch == CODE_NEWLINE) begin
         col = 0;
         row = row + 1;
      end else if (ch == CODE_BACKSPACE) begin
         // Column zero: nothing moves, nothing is written
         if (col > 0) begin
            col = col - 1;
            wr_cell.cell_address = ADDR_W'(row * SCREEN_COLUMNS + col);
            wr_cell.cell_word    = {cur_color, CODE_BLANK};
            writes = 1'b1;
         end
      end else begin
         wr_cell.cell_address = ADDR_W'(row * SCREEN_COLUMNS + col);
         wr_cell.cell_word    = {cur_color, ch};
         writes = 1'b1;
         col = col + 1;
      end
      // Wrap the column onto the next row, then the row back to the top
      if (col >= SCREEN_COLUMNS) begin
         col = 0;
         row = row + 1;
      end
      if (row >= SCREEN_ROWS)
         row = 0;
      cur_col = COL_W'(col);
      cur_row = ROW_W'(row);
      return writes;
   endfunction

   task automatic note_mismatch(input string what, input int want, input int got);
      if (errors < 10)
         $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
      errors++;
   endtask

   // Track the register, predict each character, check each cell write
   always @(posedge clock) begin
      cell_type want;
      cell_type got;
      cell_type next_cell;
      if (reset) begin
         cur_col   = '0;
         cur_row   = '0;
         cur_color = COLOR_AT_RESET;
         owed_cells.delete();
      end else begin
         if (csr_valid && csr_ready)
            cur_color = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            got = cell_type'(rsp_tdata[WORD_W+ADDR_W-1:0]);
            if (owed_cells.size() == 0) begin
               if (errors < 10)
                  $display("%0t: unexpected cell write 0x%0h", $realtime, rsp_tdata);
               errors++;
            end else begin
               want = owed_cells.pop_front();
               if (got.cell_address != want.cell_address)
                  note_mismatch("cell_address", want.cell_address, got.cell_address);
               if (got.cell_word != want.cell_word)
                  note_mismatch("cell_word", want.cell_word, got.cell_word);
            end
            if (rsp_tdata[RSP_W-1:WORD_W+ADDR_W] != '0)
               note_mismatch("pad bits", 0, rsp_tdata[RSP_W-1:WORD_W+ADDR_W]);
         end
         if (req_tvalid && req_tready) begin
            if (advance_cursor(req_tdata, next_cell))
               owed_cells.push_back(next_cell);
         end
      end
      pending = owed_cells.size();
   end

   initial begin
      pending = 0;
      errors  = 0;
   end

endmodule

// ----- verif/tb.sv -----
module tb;
   import tccw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic [CHAR_W-1:0]  req_tdata = '0;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [COLOR_W-1:0] csr_data = '0;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   int                 pending;
   int                 errors;

   // Idle rates in percent, and the long output hold request
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_req    = 0;
   int hold_seen   = 0;
   int hold_left   = 0;
   int chars_sent  = 0;

   always #2 clock = ~clock;

   text_console_cell_writer_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   tccw_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .pending    (pending),
      .errors     (errors)
   );

   // Output side: random back-pressure, or a long hold when asked
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_req != hold_seen) begin
         hold_seen  <= hold_req;
         hold_left  <= 63;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // Offer one character, with random gaps, until it is taken
   task automatic send_char(input logic [CHAR_W-1:0] ch);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      chars_sent++;
   endtask

   // Drop valid and wait until every owed cell write has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do
         @(negedge clock);
      while (pending != 0);
      // Newlines leave nothing to wait for, so idle the pipe before returning
      repeat (4) @(posedge clock);
   endtask

   task automatic write_color(input logic [COLOR_W-1:0] color);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= color;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Any character that prints, i.e. neither newline nor backspace
   function automatic logic [CHAR_W-1:0] glyph();
      logic [CHAR_W-1:0] ch;
      ch = CHAR_W'($urandom_range(0, 255));
      if (ch == CODE_NEWLINE || ch == CODE_BACKSPACE)
         ch = ch ^ 8'h40;
      return ch;
   endfunction

   // Stream text-like runs: short lines, long wrapping runs, erasures,
   // blank-line bursts and raw noise
   task automatic type_text(input int count, input int hold_at, input int pause_at);
      int stop;
      int kind;
      int len;
      stop = chars_sent + count;
      while (chars_sent < stop) begin
         if (hold_at >= 0 && chars_sent >= hold_at) begin
            hold_req <= hold_req + 1;
            hold_at = -1;
         end
         if (pause_at >= 0 && chars_sent >= pause_at) begin
            write_color(COLOR_W'($urandom_range(0, 255)));
            pause_at = -1;
         end
         kind = $urandom_range(0, 99);
         if (kind < 50) begin
            len = $urandom_range(0, 30);
            repeat (len) send_char(glyph());
            send_char(CODE_NEWLINE);
         end else if (kind < 65) begin
            len = $urandom_range(70, 170);
            repeat (len) send_char(glyph());
         end else if (kind < 80) begin
            len = $urandom_range(1, 12);
            repeat (len) send_char(CODE_BACKSPACE);
         end else if (kind < 88) begin
            len = $urandom_range(1, 30);
            repeat (len) send_char(CODE_NEWLINE);
         end else begin
            len = $urandom_range(1, 8);
            repeat (len) send_char(CHAR_W'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: erase at home, byte extremes, single bits, line control
      rx_idle_pct <= 0;
      send_char(CODE_BACKSPACE);
      send_char(8'h00);
      send_char(8'hFF);
      send_char(8'h41);
      send_char(CODE_BACKSPACE);
      send_char(CODE_BACKSPACE);
      send_char(CODE_NEWLINE);
      send_char(CODE_BACKSPACE);
      send_char(8'h55);
      send_char(8'hAA);
      send_char(CODE_BLANK);
      send_char(8'h7F);
      send_char(8'h80);
      send_char(8'h01);
      send_char(8'hFE);
      send_char(8'h09);
      send_char(8'h0B);
      send_char(CODE_NEWLINE);
      write_color(8'hFF);
      send_char(8'h5A);
      send_char(CODE_BACKSPACE);
      send_char(8'hA5);

      // Mostly busy sender, slow receiver
      write_color(8'h00);
      tx_idle_pct = 29;
      rx_idle_pct <= 74;
      type_text(600, -1, -1);

      // Slow sender, mostly ready receiver
      write_color(8'hFF);
      tx_idle_pct = 74;
      rx_idle_pct <= 29;
      type_text(600, -1, -1);

      // Full rate, with one long output hold and one full drain
      write_color(COLOR_W'($urandom_range(1, 254)));
      tx_idle_pct = 0;
      rx_idle_pct <= 0;
      type_text(600, chars_sent + 150, chars_sent + 400);

      wait_drained();
      repeat (10) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
